// ===== rtl/wheel_pulse_period_monitor_assert.svh =====
// ---------------------------------------------------------------------------
// Wheel pulse period monitor assertion macros
// Same-cycle and next-cycle implication checks, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef WHEEL_PULSE_PERIOD_MONITOR_ASSERT_SVH
`define WHEEL_PULSE_PERIOD_MONITOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wheel pulse period monitor: check failed");
`define WPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wheel pulse period monitor: check failed");
`else
`define WPM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define WPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/wpm_pkg.sv =====
// ---------------------------------------------------------------------------
// Wheel pulse period monitor package
// Shared widths, register indexes, reset values and beat structures.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wpm_pkg;

	localparam int NUM_WHEELS = 4;
	localparam int WHEEL_W    = 2;
	localparam int CFG_W      = 32;
	localparam int CNT_W      = 8;
	localparam int SUM_W      = 40;
	localparam int ROT_W      = 32;
	localparam int DIFF_W     = 41;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	localparam logic [CFG_W-1:0] RST_MIN_INTERVAL      = 32'd1000;
	localparam logic [CNT_W-1:0] RST_PULSES_PER_REPORT = 8'd10;

	localparam logic [WHEEL_W-1:0] WHEEL_FL = 2'd0;
	localparam logic [WHEEL_W-1:0] WHEEL_BL = 2'd1;
	localparam logic [WHEEL_W-1:0] WHEEL_FR = 2'd2;
	localparam logic [WHEEL_W-1:0] WHEEL_BR = 2'd3;

	typedef enum logic [0:0] {
		REG_MIN_INTERVAL      = 1'b0,
		REG_PULSES_PER_REPORT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [WHEEL_W-1:0] wheel;
		logic               accepted;
		logic [SUM_W-1:0]   interval;
	} wpm_evt_t;

	typedef struct packed {
		logic [WHEEL_W-1:0]       wheel_out;
		logic                     accepted;
		logic                     published;
		logic [SUM_W-1:0]         period_sum;
		logic [ROT_W-1:0]         rotations;
		logic signed [DIFF_W-1:0] front_difference;
		logic signed [DIFF_W-1:0] back_difference;
	} wpm_res_t;

endpackage

// ===== rtl/wpm_front.sv =====
// ---------------------------------------------------------------------------
// Wheel pulse period monitor front end
// Measures the interval since each wheel's last accepted edge and classifies it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpm_front import wpm_pkg::*; #(
	parameter int TIME_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [WHEEL_W-1:0] wheel,
	input  logic [CFG_W-1:0]   edge_time,
	input  logic [CFG_W-1:0]   min_interval,
	output wpm_evt_t           evt
);

	localparam int CW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
	localparam int EW = (TIME_WIDTH > SUM_W) ? TIME_WIDTH : SUM_W;

	logic [NUM_WHEELS-1:0][TIME_WIDTH-1:0] last_q;
	logic [TIME_WIDTH-1:0] now;
	logic [TIME_WIDTH-1:0] interval;
	logic                  pass;
	logic                  huge;

	always_comb begin
		now      = TIME_WIDTH'(edge_time);
		interval = now - last_q[wheel];
		pass     = CW'(interval) > CW'(min_interval);
		huge     = EW'(interval) > EW'(SUM_MAX);
		evt.wheel    = wheel;
		evt.accepted = pass;
		evt.interval = huge ? SUM_MAX : SUM_W'(interval);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (push && pass) begin
			last_q[wheel] <= now;
		end
	end

endmodule

// ===== rtl/wpm_fifo.sv =====
// ---------------------------------------------------------------------------
// Wheel pulse period monitor event queue
// Four-entry queue that decouples the front end from the accumulator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpm_fifo import wpm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  wpm_evt_t din,
	input  logic     pop,
	output wpm_evt_t dout,
	output logic     full,
	output logic     empty
);

	wpm_evt_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     cnt_q;

	assign full  = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/wpm_back.sv =====
// ---------------------------------------------------------------------------
// Wheel pulse period monitor back end
// Accumulates intervals, publishes reports and forms the result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wheel_pulse_period_monitor_assert.svh"

module wpm_back import wpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  wpm_evt_t         evt,
	input  logic             evt_valid,
	output logic             pop,
	input  logic [CNT_W-1:0] pulses_per_report,
	output logic             res_valid,
	input  logic             res_ready,
	output wpm_res_t         res
);

	logic [NUM_WHEELS-1:0][SUM_W-1:0] acc_q;
	logic [NUM_WHEELS-1:0][CNT_W-1:0] cnt_q;
	logic [NUM_WHEELS-1:0][ROT_W-1:0] rot_q;
	logic [NUM_WHEELS-1:0][SUM_W-1:0] pub_q;

	logic                             valid_s1;
	logic [WHEEL_W-1:0]               wheel_s1;
	logic                             acc_s1;
	logic                             pub_s1;
	logic [ROT_W-1:0]                 rots_s1;
	logic [NUM_WHEELS-1:0][SUM_W-1:0] pubs_s1;

	logic                             valid_s2;
	wpm_res_t                         res_s2;

	logic                             advance;
	logic [SUM_W:0]                   a_sum;
	logic [SUM_W-1:0]                 new_a;
	logic [CNT_W-1:0]                 cnt_n;
	logic [CNT_W-1:0]                 target;
	logic                             hit;
	logic [NUM_WHEELS-1:0][SUM_W-1:0] pubs_next;

	always_comb begin
		advance = !valid_s2 || res_ready;
		pop     = advance && evt_valid;
		a_sum   = {1'b0, acc_q[evt.wheel]} + {1'b0, evt.interval};
		new_a   = a_sum[SUM_W] ? SUM_MAX : a_sum[SUM_W-1:0];
		cnt_n   = cnt_q[evt.wheel] + 1'b1;
		target  = (pulses_per_report == '0) ? CNT_W'(1) : pulses_per_report;
		hit     = evt.accepted && (cnt_n >= target);
		for (int i = 0; i < NUM_WHEELS; i++) begin
			pubs_next[i] = (hit && (evt.wheel == WHEEL_W'(i))) ? new_a : pub_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			rot_q <= '0;
			pub_q <= '0;
		end else if (pop && evt.accepted) begin
			if (hit) begin
				pub_q[evt.wheel] <= new_a;
				rot_q[evt.wheel] <= rot_q[evt.wheel] + 1'b1;
				acc_q[evt.wheel] <= '0;
				cnt_q[evt.wheel] <= '0;
			end else begin
				acc_q[evt.wheel] <= new_a;
				cnt_q[evt.wheel] <= cnt_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= evt_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wheel_s1 <= evt.wheel;
			acc_s1   <= evt.accepted;
			pub_s1   <= hit;
			rots_s1  <= hit ? rot_q[evt.wheel] + 1'b1 : rot_q[evt.wheel];
			pubs_s1  <= pubs_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2.wheel_out        <= wheel_s1;
			res_s2.accepted         <= acc_s1;
			res_s2.published        <= pub_s1;
			res_s2.period_sum       <= pubs_s1[wheel_s1];
			res_s2.rotations        <= rots_s1;
			res_s2.front_difference <= $signed({1'b0, pubs_s1[WHEEL_FR]})
				- $signed({1'b0, pubs_s1[WHEEL_FL]});
			res_s2.back_difference  <= $signed({1'b0, pubs_s1[WHEEL_BR]})
				- $signed({1'b0, pubs_s1[WHEEL_BL]});
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

	`WPM_ASSERT_NOW(a_pub_needs_accept, clk, arst_n, valid_s2 && res_s2.published, res_s2.accepted)
	`WPM_ASSERT_NEXT(a_reject_keeps_state, clk, arst_n, pop && !evt.accepted, $stable(acc_q) && $stable(cnt_q) && $stable(pub_q) && $stable(rot_q))
	`WPM_ASSERT_NOW(a_pub_clears_sum, clk, arst_n, valid_s1 && pub_s1, (acc_q[wheel_s1] == '0) && (cnt_q[wheel_s1] == '0))

endmodule

// ===== rtl/wheel_pulse_period_monitor.sv =====
// ---------------------------------------------------------------------------
// Wheel pulse period monitor
// Per-wheel edge interval measurement with bounce rejection and reporting.
// ---------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  s_axis   in         tuser: wheel; tdata: edge_time
//  m_axis   out        tuser: wheel_out, accepted, published;
//                      tdata: period_sum, rotations, front/back difference
//  apb      in         min_interval at 0x0, pulses_per_report at 0x4
//
// One beat per cycle is sustained both ways while m_tready is high; each beat
// sees one subtract and compare in the front end and one saturating add in the
// back. An accepted input beat passes the queue, s1 and s2 before m_tvalid rises.
// A four-entry queue keeps the input flowing while the output stalls, until full.
// Reset clears all per-wheel state at once; no clearing pass follows it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wheel_pulse_period_monitor import wpm_pkg::*; #(
	parameter int TIME_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // edge_time
	input  logic [1:0]   s_tuser,   // wheel
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata,   // period_sum, rotations, front_difference,
	                                // back_difference, zero fill
	output logic [3:0]   m_tuser,   // wheel_out, accepted, published
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [CFG_W-1:0] min_interval_q;
	logic [CNT_W-1:0] pulses_per_report_q;

	reg_idx_t  reg_idx;
	logic      cfg_wr;
	logic      push;
	logic      pop;
	logic      full;
	logic      empty;
	wpm_evt_t  evt_in;
	wpm_evt_t  evt_out;
	wpm_res_t  res;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q      <= RST_MIN_INTERVAL;
			pulses_per_report_q <= RST_PULSES_PER_REPORT;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MIN_INTERVAL:      min_interval_q      <= pwdata;
				REG_PULSES_PER_REPORT: pulses_per_report_q <= pwdata[CNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MIN_INTERVAL:      prdata = min_interval_q;
			REG_PULSES_PER_REPORT: prdata = {{(CFG_W - CNT_W){1'b0}}, pulses_per_report_q};
		endcase
	end

	assign s_tready = !full;
	assign push     = s_tvalid && s_tready;

	wpm_front #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.wheel        (s_tuser),
		.edge_time    (s_tdata),
		.min_interval (min_interval_q),
		.evt          (evt_in)
	);

	wpm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (evt_in),
		.pop    (pop),
		.dout   (evt_out),
		.full   (full),
		.empty  (empty)
	);

	wpm_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.evt               (evt_out),
		.evt_valid         (!empty),
		.pop               (pop),
		.pulses_per_report (pulses_per_report_q),
		.res_valid         (m_tvalid),
		.res_ready         (m_tready),
		.res               (res)
	);

	assign m_tuser = {res.published, res.accepted, res.wheel_out};
	assign m_tdata = {6'b0, res.back_difference, res.front_difference,
		res.rotations, res.period_sum};

endmodule
